// File: src/ulsc_pkg.sv
package ulsc_pkg;

    localparam int FREQ_W     = 20;
    localparam int ROC_W      = 34;
    localparam int ROC_TH_W   = 33;
    localparam int WIN_W      = 16;
    localparam int TICK_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 33;

    // serial multiplier: 40-bit multiplicand, 20-bit multiplier, 4-bit digits
    localparam int MUL_A_W     = 40;
    localparam int MUL_B_W     = 20;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int DIG_W       = 4;
    localparam int MUL_STEPS   = MUL_B_W / DIG_W;
    localparam int MUL_CNT_W   = 3;

    // (diff * f * p * 2) / 256 == product >> 7
    localparam int NUM_SHIFT   = 7;
    localparam int DIV_N_W     = MUL_P_W - NUM_SHIFT;
    localparam int DIV_D_W     = FREQ_W + 1;
    localparam int DIV_Q_W     = ROC_W;
    localparam int DIV_STEPS   = DIV_Q_W;
    localparam int DIV_CNT_W   = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_TH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROC_TH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd2;

    localparam logic [FREQ_W-1:0]   FREQ_TH_RST = 20'd12544;
    localparam logic [ROC_TH_W-1:0] ROC_TH_RST  = 33'd2560;
    localparam logic [WIN_W-1:0]    WINDOW_RST  = 16'd500;

    localparam logic ACTION_SAMPLE = 1'b0;
    localparam logic ACTION_EVAL   = 1'b1;

    localparam logic signed [ROC_W-1:0] ROC_MAX = {1'b0, {(ROC_W-1){1'b1}}};
    localparam logic signed [ROC_W-1:0] ROC_MIN = {1'b1, {(ROC_W-1){1'b0}}};

    typedef enum logic [1:0] {
        MODE_STARTUP = 2'd0,
        MODE_NORMAL  = 2'd1,
        MODE_MANAGE  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        CMD_NONE      = 2'd0,
        CMD_SHED      = 2'd1,
        CMD_RECONNECT = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_MUL1,
        S_MUL2,
        S_DIV,
        S_FIN,
        S_EVAL
    } t_state;

    typedef struct packed {
        logic [TICK_W-1:0] now;
        logic              one_left;
        logic              button;
    } t_eval_req;

    typedef struct packed {
        t_mode mode;
        t_cmd  cmd;
        logic  maint;
    } t_eval_res;

endpackage

// File: src/underfrequency_load_shed_controller.sv
// Underfrequency load-shed controller.
// Input channel (i_valid / o_stall): each transfer is either a frequency
// sample (action 0) or a periodic evaluation (action 1). Output channel
// (o_valid / i_stall): exactly one result per input item, in order.
// Configuration: i_cfg_we writes register i_cfg_idx (0 frequency threshold,
// 1 rate-of-change threshold, 2 stability window); writes to index 3 are
// dropped. Write only while the block is idle.
// Sample: rate of change goes through a 4-bit digit-serial multiplier twice
// and then a radix-2 divider; the result is loaded into the output register
// from S_FIN once that register is free, and the next item is taken when
// the block is back in idle.
// Evaluation: the result is loaded from S_EVAL once the output is free.
// One item is in work at a time; o_stall is high while it is.
// A finished result sits in the output register; the next item is accepted
// while it waits, but its own result is held back until the register frees.
// Reset (synchronous, active low) restores the threshold defaults, startup
// mode, zero held frequency and rate of change, and empties the output.
module underfrequency_load_shed_controller (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_action,
    input  logic [ulsc_pkg::FREQ_W-1:0]            i_freq_sample,
    input  logic [ulsc_pkg::TICK_W-1:0]            i_now_ticks,
    input  logic                                   i_one_load_left,
    input  logic                                   i_button_pressed,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_kind,
    output logic [ulsc_pkg::FREQ_W-1:0]            o_freq_out,
    output logic signed [ulsc_pkg::ROC_W-1:0]      o_roc_out,
    output logic [1:0]                             o_mode,
    output logic [1:0]                             o_load_command,
    output logic                                   o_maintenance,
    input  logic                                   i_cfg_we,
    input  logic [ulsc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [ulsc_pkg::CFG_DATA_W-1:0]        i_cfg_wdata
);

    localparam int FW = ulsc_pkg::FREQ_W;
    localparam int RW = ulsc_pkg::ROC_W;
    localparam int AW = ulsc_pkg::MUL_A_W;
    localparam int PW = ulsc_pkg::MUL_P_W;
    localparam int DW = ulsc_pkg::DIV_D_W;

    // configuration
    logic [FW-1:0]                  r_freq_th;
    logic [ulsc_pkg::ROC_TH_W-1:0]  r_roc_th;
    logic [ulsc_pkg::WIN_W-1:0]     r_win;

    // sequencer and datapath
    ulsc_pkg::t_state               r_state, n_state;
    logic                           r_action;
    logic [FW-1:0]                  r_f;
    ulsc_pkg::t_eval_req            r_req;
    logic [FW-1:0]                  r_prev_freq;
    logic signed [RW-1:0]           r_last_roc;

    logic                           w_accept;
    logic                           w_out_free;
    logic                           w_load;
    logic                           w_commit;
    logic                           w_neg;
    logic [FW-1:0]                  w_diff;
    logic [DW-1:0]                  w_sum;
    logic signed [RW-1:0]           w_roc;

    logic                           w_mul_start;
    logic [AW-1:0]                  w_mul_a;
    logic [ulsc_pkg::MUL_B_W-1:0]   w_mul_b;
    logic                           w_mul_done;
    logic [PW-1:0]                  w_prod;
    logic                           w_div_start;
    logic                           w_div_done;
    logic [ulsc_pkg::DIV_Q_W-1:0]   w_quot;

    ulsc_pkg::t_eval_res            w_res;
    ulsc_pkg::t_eval_res            w_cur;

    // output register
    logic                           r_o_valid;
    logic                           r_o_kind;
    logic [FW-1:0]                  r_o_freq;
    logic signed [RW-1:0]           r_o_roc;
    ulsc_pkg::t_eval_res            r_o_res;
    logic                           n_o_kind;
    logic [FW-1:0]                  n_o_freq;
    logic signed [RW-1:0]           n_o_roc;
    ulsc_pkg::t_eval_res            n_o_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_th <= ulsc_pkg::FREQ_TH_RST;
            r_roc_th  <= ulsc_pkg::ROC_TH_RST;
            r_win     <= ulsc_pkg::WINDOW_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ulsc_pkg::CFG_FREQ_TH: r_freq_th <= i_cfg_wdata[FW-1:0];
                ulsc_pkg::CFG_ROC_TH:  r_roc_th  <= i_cfg_wdata[ulsc_pkg::ROC_TH_W-1:0];
                ulsc_pkg::CFG_WINDOW:  r_win     <= i_cfg_wdata[ulsc_pkg::WIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_stall    = (r_state != ulsc_pkg::S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_o_valid || !i_stall;

    assign w_neg  = r_f < r_prev_freq;
    assign w_diff = w_neg ? (r_prev_freq - r_f) : (r_f - r_prev_freq);
    assign w_sum  = {1'b0, r_f} + {1'b0, r_prev_freq};

    // quotient magnitude stays below 2^33; saturation kept as a guard
    always_comb begin
        if (w_sum == '0) begin
            w_roc = '0;
        end else if (!w_neg) begin
            w_roc = w_quot[RW-1] ? ulsc_pkg::ROC_MAX : $signed(w_quot);
        end else begin
            w_roc = w_quot[RW-1] ? ulsc_pkg::ROC_MIN : -$signed(w_quot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ulsc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_mul_start = 1'b0;
        w_div_start = 1'b0;
        w_mul_a     = w_prod[AW-1:0];
        w_mul_b     = r_prev_freq;
        w_load      = 1'b0;
        w_commit    = 1'b0;
        unique case (r_state)
            ulsc_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_action == ulsc_pkg::ACTION_EVAL) ?
                              ulsc_pkg::S_EVAL : ulsc_pkg::S_START;
                end
            end
            ulsc_pkg::S_START: begin
                // first pass: |f - p| * f
                w_mul_start = 1'b1;
                w_mul_a     = {{(AW-FW){1'b0}}, w_diff};
                w_mul_b     = r_f;
                n_state     = ulsc_pkg::S_MUL1;
            end
            ulsc_pkg::S_MUL1: begin
                // second pass: times p
                if (w_mul_done) begin
                    w_mul_start = 1'b1;
                    n_state     = ulsc_pkg::S_MUL2;
                end
            end
            ulsc_pkg::S_MUL2: begin
                if (w_mul_done) begin
                    w_div_start = 1'b1;
                    n_state     = ulsc_pkg::S_DIV;
                end
            end
            ulsc_pkg::S_DIV: begin
                if (w_div_done) begin
                    n_state = ulsc_pkg::S_FIN;
                end
            end
            ulsc_pkg::S_FIN: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = ulsc_pkg::S_IDLE;
                end
            end
            ulsc_pkg::S_EVAL: begin
                if (w_out_free) begin
                    w_load   = 1'b1;
                    w_commit = 1'b1;
                    n_state  = ulsc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ulsc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_action;
            r_f      <= i_freq_sample;
            r_req    <= '{now: i_now_ticks, one_left: i_one_load_left,
                          button: i_button_pressed};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_freq <= '0;
            r_last_roc  <= '0;
        end else if (w_load && (r_state == ulsc_pkg::S_FIN)) begin
            r_prev_freq <= r_f;
            r_last_roc  <= w_roc;
        end
    end

    ulsc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    ulsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod[PW-1:ulsc_pkg::NUM_SHIFT]),
        .i_den   (w_sum),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    ulsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_commit    (w_commit),
        .i_req       (r_req),
        .i_prev_freq (r_prev_freq),
        .i_last_roc  (r_last_roc),
        .i_freq_th   (r_freq_th),
        .i_roc_th    (r_roc_th),
        .i_win       (r_win),
        .o_res       (w_res),
        .o_cur       (w_cur)
    );

    always_comb begin
        if (r_state == ulsc_pkg::S_EVAL) begin
            n_o_kind = ulsc_pkg::ACTION_EVAL;
            n_o_freq = r_prev_freq;
            n_o_roc  = r_last_roc;
            n_o_res  = w_res;
        end else begin
            n_o_kind = ulsc_pkg::ACTION_SAMPLE;
            n_o_freq = r_f;
            n_o_roc  = w_roc;
            n_o_res  = w_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_kind <= n_o_kind;
            r_o_freq <= n_o_freq;
            r_o_roc  <= n_o_roc;
            r_o_res  <= n_o_res;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_kind         = r_o_kind;
    assign o_freq_out     = r_o_freq;
    assign o_roc_out      = r_o_roc;
    assign o_mode         = r_o_res.mode;
    assign o_load_command = r_o_res.cmd;
    assign o_maintenance  = r_o_res.maint;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ulsc_pkg::S_START || r_state == ulsc_pkg::S_EVAL)
                     && (r_action == $past(i_action)))
        else $error("accepted item did not start work");

    a_sample_no_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == ulsc_pkg::ACTION_SAMPLE)) |->
            (o_load_command == ulsc_pkg::CMD_NONE))
        else $error("load command on a sample result");

    a_held_values_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_freq_out == r_prev_freq) && (o_roc_out == r_last_roc))
        else $error("result disagrees with held frequency or rate of change");

endmodule

// File: src/ulsc_mul.sv
module ulsc_mul (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [ulsc_pkg::MUL_A_W-1:0]     i_a,
    input  logic [ulsc_pkg::MUL_B_W-1:0]     i_b,
    output logic                             o_done,
    output logic [ulsc_pkg::MUL_P_W-1:0]     o_prod
);

    localparam int AW = ulsc_pkg::MUL_A_W;
    localparam int BW = ulsc_pkg::MUL_B_W;
    localparam int PW = ulsc_pkg::MUL_P_W;
    localparam int DW = ulsc_pkg::DIG_W;
    localparam int CW = ulsc_pkg::MUL_CNT_W;

    logic [AW-1:0]    r_a;
    logic [PW-1:0]    r_p;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [AW+DW-1:0] w_pp;
    logic [AW+DW-1:0] w_sum;

    // multiplier digits leave at the bottom, partial sum enters at the top
    assign w_pp  = {{DW{1'b0}}, r_a} * {{AW{1'b0}}, r_p[DW-1:0]};
    assign w_sum = {{DW{1'b0}}, r_p[PW-1:BW]} + w_pp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(ulsc_pkg::MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {{AW{1'b0}}, i_b};
        end else if (r_busy) begin
            r_p <= {w_sum, r_p[BW-1:DW]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule

// File: src/ulsc_div.sv
module ulsc_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [ulsc_pkg::DIV_N_W-1:0]   i_num,
    input  logic [ulsc_pkg::DIV_D_W-1:0]   i_den,
    output logic                           o_done,
    output logic [ulsc_pkg::DIV_Q_W-1:0]   o_quot
);

    localparam int NW = ulsc_pkg::DIV_N_W;
    localparam int DW = ulsc_pkg::DIV_D_W;
    localparam int QW = ulsc_pkg::DIV_Q_W;
    localparam int CW = ulsc_pkg::DIV_CNT_W;

    logic [DW-1:0] r_den;
    logic [DW-1:0] r_rem;
    logic [QW-1:0] r_q;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   w_t;
    logic [DW:0]   w_sub;
    logic          w_ge;

    // restoring radix-2: one quotient bit per cycle; the upper dividend
    // bits are below the divisor because the quotient fits in QW bits
    assign w_t   = {r_rem, r_q[QW-1]};
    assign w_ge  = w_t >= {1'b0, r_den};
    assign w_sub = w_t - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(ulsc_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= {{(DW-(NW-QW)){1'b0}}, i_num[NW-1:QW]};
            r_q   <= i_num[QW-1:0];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[DW-1:0] : w_t[DW-1:0];
            r_q   <= {r_q[QW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// File: src/ulsc_ctrl.sv
module ulsc_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_commit,
    input  ulsc_pkg::t_eval_req               i_req,
    input  logic [ulsc_pkg::FREQ_W-1:0]       i_prev_freq,
    input  logic signed [ulsc_pkg::ROC_W-1:0] i_last_roc,
    input  logic [ulsc_pkg::FREQ_W-1:0]       i_freq_th,
    input  logic [ulsc_pkg::ROC_TH_W-1:0]     i_roc_th,
    input  logic [ulsc_pkg::WIN_W-1:0]        i_win,
    output ulsc_pkg::t_eval_res               o_res,
    output ulsc_pkg::t_eval_res               o_cur
);

    localparam int TW = ulsc_pkg::TICK_W;
    localparam int RW = ulsc_pkg::ROC_W;

    ulsc_pkg::t_mode r_mode, n_mode;
    logic [TW-1:0]   r_ws, n_ws;
    logic            r_stab_v, n_stab_v;
    logic            r_stab, n_stab;
    logic            r_maint, n_maint;
    ulsc_pkg::t_cmd  w_cmd;

    logic [RW-1:0]   w_roc_mag;
    logic            w_brk;
    logic            w_stab;
    logic [TW-1:0]   w_ws_eff;
    logic [TW-1:0]   w_age;
    logic            w_elapsed;

    assign w_roc_mag = i_last_roc[RW-1] ? (~i_last_roc + 1'b1) : i_last_roc;
    assign w_brk     = (i_prev_freq < i_freq_th) || (w_roc_mag > {1'b0, i_roc_th});
    assign w_stab    = !w_brk;
    // stability flip restarts the window
    assign w_ws_eff  = (r_stab_v && (w_stab != r_stab)) ? i_req.now : r_ws;
    assign w_age     = i_req.now - w_ws_eff;
    assign w_elapsed = w_age >= {{(TW-ulsc_pkg::WIN_W){1'b0}}, i_win};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= ulsc_pkg::MODE_STARTUP;
            r_ws     <= '0;
            r_stab_v <= 1'b0;
            r_stab   <= 1'b0;
            r_maint  <= 1'b0;
        end else begin
            r_mode   <= n_mode;
            r_ws     <= n_ws;
            r_stab_v <= n_stab_v;
            r_stab   <= n_stab;
            r_maint  <= n_maint;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_ws     = r_ws;
        n_stab_v = r_stab_v;
        n_stab   = r_stab;
        n_maint  = r_maint;
        w_cmd    = ulsc_pkg::CMD_NONE;
        if (i_commit) begin
            unique case (r_mode)
                ulsc_pkg::MODE_NORMAL: begin
                    if (w_brk) begin
                        n_ws   = i_req.now;
                        n_mode = ulsc_pkg::MODE_MANAGE;
                        w_cmd  = ulsc_pkg::CMD_SHED;
                    end
                end
                ulsc_pkg::MODE_MANAGE: begin
                    n_stab_v = 1'b1;
                    n_stab   = w_stab;
                    n_ws     = w_ws_eff;
                    if (w_elapsed) begin
                        n_ws = i_req.now;
                        if (w_brk) begin
                            w_cmd = ulsc_pkg::CMD_SHED;
                        end else begin
                            w_cmd = ulsc_pkg::CMD_RECONNECT;
                            if (i_req.one_left) begin
                                n_mode = ulsc_pkg::MODE_NORMAL;
                            end
                        end
                    end
                end
                default: begin
                    n_mode = ulsc_pkg::MODE_NORMAL;
                end
            endcase
            if (i_req.button) begin
                if (r_maint) begin
                    n_maint = 1'b0;
                    n_mode  = ulsc_pkg::MODE_NORMAL;
                end else begin
                    n_maint = 1'b1;
                    n_mode  = ulsc_pkg::MODE_MANAGE;
                end
            end
        end
    end

    assign o_res = '{mode: n_mode, cmd: w_cmd, maint: n_maint};
    assign o_cur = '{mode: r_mode, cmd: ulsc_pkg::CMD_NONE, maint: r_maint};

    a_mode_left_startup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_commit |=> r_mode != ulsc_pkg::MODE_STARTUP)
        else $error("mode still startup after an evaluation");

    a_button_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_commit && i_req.button) |=> r_maint != $past(r_maint))
        else $error("button did not toggle maintenance flag");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_commit |=> ($stable(r_mode) && $stable(r_maint) && $stable(r_ws)))
        else $error("controller state moved without an evaluation");

endmodule
